FILE: hw/rtl/bitplane_index_code_converter_defines.svh
// ----------------------------------------------------------------------------
// bitplane_index_code_converter_defines.svh
// Assertion macros shared by the bitplane index/code converter.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_INDEX_CODE_CONVERTER_DEFINES_SVH
`define BITPLANE_INDEX_CODE_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BICC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bicc assertion failed");

// Next-cycle implication, disabled during reset.
`define BICC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bicc assertion failed");

`endif

FILE: hw/rtl/bicc_pkg.sv
// ----------------------------------------------------------------------------
// bicc_pkg
// Types, codes and plane tables for the bitplane index/code converter.
// ----------------------------------------------------------------------------
package bicc_pkg;

    localparam int NUM_SLOTS = 12;
    localparam int CODE_W    = 32;
    localparam int INDEX_W   = 12;

    localparam logic [31:0] MASK_SINGLE = 32'h0000_3f3f;
    localparam logic [31:0] MASK_DISP_A = 32'h000f_00ff;
    localparam logic [31:0] MASK_DISP_B = 32'h0f00_ff00;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic REG_SIG_PLANES   = 1'b0;
    localparam logic REG_DISPLAY_MODE = 1'b1;

    typedef enum logic [1:0] {
        MODE_SINGLE  = 2'd0,
        MODE_DISP_A  = 2'd1,
        MODE_DISP_B  = 2'd2,
        MODE_INVALID = 2'd3
    } display_mode_t;

    typedef logic [4:0] plane_pos_t;

    // Candidate planes of each mode, in significance order.
    localparam plane_pos_t POS_SINGLE [NUM_SLOTS] = '{
        5'd0, 5'd8, 5'd1, 5'd9, 5'd2, 5'd10, 5'd3, 5'd11, 5'd4, 5'd12, 5'd5, 5'd13
    };
    localparam plane_pos_t POS_DISP_A [NUM_SLOTS] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd16, 5'd17, 5'd18, 5'd19
    };
    localparam plane_pos_t POS_DISP_B [NUM_SLOTS] = '{
        5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd24, 5'd25, 5'd26, 5'd27
    };

    typedef struct packed {
        logic [31:0]   sig_planes;
        display_mode_t display_mode;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]  plane_code;
        logic [INDEX_W-1:0] index;
        logic               error;
    } result_t;

endpackage

FILE: hw/rtl/bicc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bicc_cfg_regs
// APB register file: significant planes mask and display mode.
// ----------------------------------------------------------------------------
module bicc_cfg_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output bicc_pkg::cfg_t cfg
);

    logic [31:0]             sig_planes_reg;
    bicc_pkg::display_mode_t display_mode_reg;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_planes_reg   <= 32'hffff_ffff;
            display_mode_reg <= bicc_pkg::MODE_SINGLE;
        end else if (wr_en) begin
            case (paddr[2])
                bicc_pkg::REG_SIG_PLANES: begin
                    sig_planes_reg <= pwdata;
                end
                bicc_pkg::REG_DISPLAY_MODE: begin
                    display_mode_reg <= bicc_pkg::display_mode_t'(pwdata[1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bicc_pkg::REG_SIG_PLANES:   prdata = sig_planes_reg;
            bicc_pkg::REG_DISPLAY_MODE: prdata = {30'd0, display_mode_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.sig_planes   = sig_planes_reg;
    assign cfg.display_mode = display_mode_reg;

endmodule

FILE: hw/rtl/bicc_convert.sv
// ----------------------------------------------------------------------------
// bicc_convert
// Combinational deposit/extract between a color index and a plane code.
// ----------------------------------------------------------------------------
module bicc_convert (
    input  logic                           operation,
    input  logic [bicc_pkg::INDEX_W-1:0]   color_index,
    input  logic [bicc_pkg::CODE_W-1:0]    plane_code_in,
    input  bicc_pkg::cfg_t                 cfg,
    output bicc_pkg::result_t              result
);

    bicc_pkg::plane_pos_t          pos  [bicc_pkg::NUM_SLOTS];
    logic [3:0]                    rank [bicc_pkg::NUM_SLOTS];
    logic [31:0]                   mode_mask;
    logic [31:0]                   eff_mask;
    logic [bicc_pkg::NUM_SLOTS-1:0] sel;
    logic [3:0]                    num_sel;
    logic                          mode_bad;
    logic                          too_big;
    logic [bicc_pkg::CODE_W-1:0]   code;
    logic [bicc_pkg::INDEX_W-1:0]  index;

    always_comb begin
        mode_bad = 1'b0;
        case (cfg.display_mode)
            bicc_pkg::MODE_SINGLE: begin
                mode_mask = bicc_pkg::MASK_SINGLE;
                pos       = bicc_pkg::POS_SINGLE;
            end
            bicc_pkg::MODE_DISP_A: begin
                mode_mask = bicc_pkg::MASK_DISP_A;
                pos       = bicc_pkg::POS_DISP_A;
            end
            bicc_pkg::MODE_DISP_B: begin
                mode_mask = bicc_pkg::MASK_DISP_B;
                pos       = bicc_pkg::POS_DISP_B;
            end
            default: begin
                mode_mask = 32'd0;
                pos       = bicc_pkg::POS_SINGLE;
                mode_bad  = 1'b1;
            end
        endcase
    end

    assign eff_mask = cfg.sig_planes & mode_mask;

    // Rank of each slot: number of selected slots ahead of it.
    always_comb begin
        for (int j = 0; j < bicc_pkg::NUM_SLOTS; j++) begin
            sel[j]  = eff_mask[pos[j]];
        end
        for (int j = 0; j < bicc_pkg::NUM_SLOTS; j++) begin
            rank[j] = 4'($countones(sel & ((bicc_pkg::NUM_SLOTS'(1) << j)
                                          - bicc_pkg::NUM_SLOTS'(1))));
        end
        num_sel = 4'($countones(sel));
    end

    always_comb begin
        code  = '0;
        index = '0;
        for (int j = 0; j < bicc_pkg::NUM_SLOTS; j++) begin
            if (sel[j]) begin
                code[pos[j]]   = color_index[rank[j]];
                index[rank[j]] = plane_code_in[pos[j]];
            end
        end
    end

    // Index too wide for the selected planes.
    assign too_big = (num_sel < 4'(bicc_pkg::INDEX_W)) && ((color_index >> num_sel) != '0);

    always_comb begin
        result.error      = mode_bad || ((operation == bicc_pkg::OP_ENCODE) && too_big);
        result.plane_code = (result.error || operation == bicc_pkg::OP_DECODE) ? '0 : code;
        result.index      = (result.error || operation == bicc_pkg::OP_ENCODE) ? '0 : index;
    end

endmodule

FILE: hw/rtl/bitplane_index_code_converter.sv
// ----------------------------------------------------------------------------
// bitplane_index_code_converter
// Converts a color index to a bitplane code and back, one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: operation; tdata: color_index, plane_code_in
//  m_axis    out        tuser: error; tdata: plane_code_out, index_out
//  apb       in/out     sig_planes at 0x0, display_mode at 0x4
//
//  An accepted item moves from the input register to the result register,
//  where its result becomes valid; one item per cycle is sustained while
//  m_tready stays high. Synchronous active-low reset clears both valid flags.
//  A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
`include "bitplane_index_code_converter_defines.svh"

module bitplane_index_code_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // color_index[11:0], plane_code_in[43:12], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // plane_code_out[31:0], index_out[43:32], zero pad
    output logic        m_tuser,   // error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bicc_pkg::cfg_t    cfg;
    bicc_pkg::result_t conv_result;
    bicc_pkg::result_t result_reg;

    logic                          in_valid_reg;
    logic                          out_valid_reg;
    logic                          operation_reg;
    logic [bicc_pkg::INDEX_W-1:0]  color_index_reg;
    logic [bicc_pkg::CODE_W-1:0]   plane_code_in_reg;
    logic                          advance;
    logic                          in_take;

    bicc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bicc_convert u_convert (
        .operation     (operation_reg),
        .color_index   (color_index_reg),
        .plane_code_in (plane_code_in_reg),
        .cfg           (cfg),
        .result        (conv_result)
    );

    // Move the input register into the result register when it is free.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            operation_reg     <= s_tuser;
            color_index_reg   <= s_tdata[11:0];
            plane_code_in_reg <= s_tdata[43:12];
        end
        if (advance && in_valid_reg) begin
            result_reg <= conv_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, result_reg.index, result_reg.plane_code};
    assign m_tuser  = result_reg.error;

    `BICC_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 48'd0)
    `BICC_ASSERT_IMP(a_one_field, aclk, aresetn,
                     m_tvalid && (m_tdata[31:0] != 32'd0), m_tdata[43:32] == 12'd0)
    `BICC_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_tready,
                     in_valid_reg && out_valid_reg && !m_tready)
    `BICC_ASSERT_NXT(a_bad_mode, aclk, aresetn,
                     in_valid_reg && advance
                     && (cfg.display_mode == bicc_pkg::MODE_INVALID),
                     m_tvalid && m_tuser)

endmodule
